/* src/dmc_pkg.sv */
// ----------------------------------------------------------------------------
// dmc_pkg
// Shared types and constants for the direct-mapped read cache.
// ----------------------------------------------------------------------------
package dmc_pkg;

    localparam int ADDR_W  = 12;
    localparam int BYTE_W  = 8;
    localparam int TAG_W   = 5;
    localparam int LINE_W  = 3;
    localparam int WORD_W  = 4;
    localparam int BLOCK_W = 8;
    localparam int CNT_W   = 32;
    localparam int COST_W  = 8;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    localparam logic REG_HIT_COST  = 1'b0;
    localparam logic REG_MISS_COST = 1'b1;

    localparam logic [COST_W-1:0] HIT_COST_RESET  = 8'd1;
    localparam logic [COST_W-1:0] MISS_COST_RESET = 8'd20;

    localparam logic [CNT_W-1:0] CNT_MAX = 32'hFFFF_FFFF;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_LOOKUP = 5'b00010,
        ST_FILL   = 5'b00100,
        ST_DRAIN  = 5'b01000,
        ST_DONE   = 5'b10000
    } state_t;

endpackage

/* src/dmc_in_if.sv */
// ----------------------------------------------------------------------------
// dmc_in_if
// Request channel: command, address and byte to store, valid/ready handshake.
// ----------------------------------------------------------------------------
interface dmc_in_if;

    logic                        valid;
    logic                        ready;
    logic                        command;
    logic [dmc_pkg::ADDR_W-1:0]  address;
    logic [dmc_pkg::BYTE_W-1:0]  ram_byte;

    modport source (output valid, output command, output address, output ram_byte,
                    input ready);
    modport sink   (input valid, input command, input address, input ram_byte,
                    output ready);

endinterface

/* src/dmc_out_if.sv */
// ----------------------------------------------------------------------------
// dmc_out_if
// Response channel: read byte, address fields, hit flag and counters.
// ----------------------------------------------------------------------------
interface dmc_out_if;

    logic                        valid;
    logic                        ready;
    logic                        hit;
    logic [dmc_pkg::BYTE_W-1:0]  read_byte;
    logic [dmc_pkg::TAG_W-1:0]   tag;
    logic [dmc_pkg::LINE_W-1:0]  line_index;
    logic [dmc_pkg::WORD_W-1:0]  word_offset;
    logic [dmc_pkg::BLOCK_W-1:0] block_number;
    logic [dmc_pkg::CNT_W-1:0]   miss_count;
    logic [dmc_pkg::CNT_W-1:0]   access_count;
    logic [dmc_pkg::CNT_W-1:0]   elapsed_time;

    modport source (output valid, output hit, output read_byte, output tag,
                    output line_index, output word_offset, output block_number,
                    output miss_count, output access_count, output elapsed_time,
                    input ready);
    modport sink   (input valid, input hit, input read_byte, input tag,
                    input line_index, input word_offset, input block_number,
                    input miss_count, input access_count, input elapsed_time,
                    output ready);

endinterface

/* src/direct_mapped_cache_read.sv */
// ----------------------------------------------------------------------------
// direct_mapped_cache_read
// Read-only direct-mapped cache in front of a byte-wide backing memory.
// ----------------------------------------------------------------------------
// A write item stores one byte into the backing memory and gives no result. A
// read item looks up the line's tag in a synchronous tag memory: a miss first
// refills the line from the single-port backing memory one byte per cycle. One
// read is in flight at a time; a finished result waits in the output register
// while the next item is accepted. Per-line valid bits are cleared at reset,
// so no clearing pass is needed. LINE_BYTES, NUM_LINES and MEMORY_BYTES must
// be powers of two; the block itself does not enforce it. Reading a backing
// byte that was never written returns an undefined value.
// ----------------------------------------------------------------------------
module direct_mapped_cache_read #(
    parameter int NUM_LINES    = 8,
    parameter int LINE_BYTES   = 16,
    parameter int MEMORY_BYTES = 4096
) (
    input  logic                         clk,
    input  logic                         rst_n,
    dmc_in_if.sink                       request,
    dmc_out_if.source                    response,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [dmc_pkg::APB_AW-1:0]   paddr,
    input  logic [dmc_pkg::APB_DW-1:0]   pwdata,
    output logic [dmc_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);

    localparam int WORD_BITS = $clog2(LINE_BYTES);
    localparam int LINE_BITS = $clog2(NUM_LINES);
    localparam int MEM_BITS  = $clog2(MEMORY_BYTES);
    localparam int TAG_RAW   = dmc_pkg::ADDR_W - WORD_BITS - LINE_BITS;
    localparam int TAG_BITS  = (TAG_RAW < 1) ? 1 : TAG_RAW;
    localparam int LM_BITS   = LINE_BITS + WORD_BITS;
    localparam int XA_W      = 16;
    localparam logic [WORD_BITS-1:0] LAST_WORD = WORD_BITS'(LINE_BYTES - 1);

    // memories
    logic [dmc_pkg::BYTE_W-1:0] bk_mem   [MEMORY_BYTES];
    logic [dmc_pkg::BYTE_W-1:0] line_mem [NUM_LINES * LINE_BYTES];
    logic [TAG_BITS-1:0]        tag_mem  [NUM_LINES];

    // control state
    dmc_pkg::state_t               state_reg, state_next;
    logic [NUM_LINES-1:0]          valid_reg, valid_next;
    logic [WORD_BITS-1:0]          cnt_reg, cnt_next;
    logic                          fwr_valid_reg, fwr_valid_next;
    logic                          out_valid_reg, out_valid_next;
    logic [dmc_pkg::COST_W-1:0]    hit_cost_reg, hit_cost_next;
    logic [dmc_pkg::COST_W-1:0]    miss_cost_reg, miss_cost_next;
    logic [dmc_pkg::CNT_W-1:0]     misses_reg, misses_next;
    logic [dmc_pkg::CNT_W-1:0]     reads_reg, reads_next;
    logic [dmc_pkg::CNT_W-1:0]     time_reg, time_next;

    // payload
    logic [dmc_pkg::ADDR_W-1:0]    addr_reg;
    logic [WORD_BITS-1:0]          fwr_idx_reg;
    logic                          hit_reg;
    logic [dmc_pkg::BYTE_W-1:0]    byte_reg;
    logic [dmc_pkg::BYTE_W-1:0]    bk_rdata_reg;
    logic [dmc_pkg::BYTE_W-1:0]    line_rdata_reg;
    logic [TAG_BITS-1:0]           tag_rdata_reg;
    logic                          out_hit_reg;
    logic [dmc_pkg::BYTE_W-1:0]    out_byte_reg;
    logic [dmc_pkg::ADDR_W-1:0]    out_addr_reg;

    // address split
    logic [WORD_BITS-1:0]          acc_word, cur_word, out_word;
    logic [LINE_BITS-1:0]          acc_line, cur_line, out_line;
    logic [TAG_BITS-1:0]           cur_tag;
    logic [XA_W-1:0]               fill_base;

    logic                          in_accept;
    logic                          slot_free;
    logic                          lookup_hit;
    logic                          out_load;
    logic                          cfg_write;
    logic                          bk_we;
    logic [MEM_BITS-1:0]           bk_addr;
    logic                          lm_we;
    logic [LM_BITS-1:0]            lm_addr;
    logic                          tag_we;
    logic [LINE_BITS-1:0]          tag_addr;
    logic [dmc_pkg::CNT_W:0]       misses_sum, reads_sum, time_sum;
    logic [dmc_pkg::CNT_W-1:0]     cost_sel;

    assign acc_word  = WORD_BITS'(request.address);
    assign acc_line  = LINE_BITS'(request.address >> WORD_BITS);
    assign cur_word  = WORD_BITS'(addr_reg);
    assign cur_line  = LINE_BITS'(addr_reg >> WORD_BITS);
    assign cur_tag   = TAG_BITS'(addr_reg >> (WORD_BITS + LINE_BITS));
    assign out_word  = WORD_BITS'(out_addr_reg);
    assign out_line  = LINE_BITS'(out_addr_reg >> WORD_BITS);
    assign fill_base = XA_W'(addr_reg >> WORD_BITS) << WORD_BITS;

    assign request.ready = (state_reg == dmc_pkg::ST_IDLE);
    assign in_accept     = request.valid && request.ready;
    assign slot_free     = !out_valid_reg || response.ready;
    assign lookup_hit    = valid_reg[cur_line] && (tag_rdata_reg == cur_tag);
    assign out_load      = (state_reg == dmc_pkg::ST_DONE) && slot_free;

    // memory ports
    assign bk_we    = in_accept && (request.command == dmc_pkg::CMD_WRITE);
    assign bk_addr  = (state_reg == dmc_pkg::ST_FILL)
                    ? MEM_BITS'(fill_base | XA_W'(cnt_reg))
                    : MEM_BITS'(XA_W'(request.address));
    assign lm_we    = fwr_valid_reg;
    assign lm_addr  = fwr_valid_reg ? {cur_line, fwr_idx_reg} : {acc_line, acc_word};
    assign tag_we   = (state_reg == dmc_pkg::ST_LOOKUP) && !lookup_hit;
    assign tag_addr = tag_we ? cur_line : acc_line;

    always_ff @(posedge clk)
    begin
        if (bk_we)
        begin
            bk_mem[bk_addr] <= request.ram_byte;
        end
        bk_rdata_reg <= bk_mem[bk_addr];
    end

    always_ff @(posedge clk)
    begin
        if (lm_we)
        begin
            line_mem[lm_addr] <= bk_rdata_reg;
        end
        line_rdata_reg <= line_mem[lm_addr];
    end

    always_ff @(posedge clk)
    begin
        if (tag_we)
        begin
            tag_mem[tag_addr] <= cur_tag;
        end
        tag_rdata_reg <= tag_mem[tag_addr];
    end

    // saturating counters
    assign cost_sel   = hit_reg ? dmc_pkg::CNT_W'(hit_cost_reg)
                                : dmc_pkg::CNT_W'(miss_cost_reg);
    assign misses_sum = {1'b0, misses_reg} + (dmc_pkg::CNT_W + 1)'(!hit_reg);
    assign reads_sum  = {1'b0, reads_reg} + (dmc_pkg::CNT_W + 1)'(1);
    assign time_sum   = {1'b0, time_reg} + {1'b0, cost_sel};

    // configuration
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_comb
    begin
        case (paddr[2])
            dmc_pkg::REG_HIT_COST:  prdata = dmc_pkg::APB_DW'(hit_cost_reg);
            dmc_pkg::REG_MISS_COST: prdata = dmc_pkg::APB_DW'(miss_cost_reg);
            default:                prdata = '0;
        endcase
    end

    always_comb
    begin
        hit_cost_next  = hit_cost_reg;
        miss_cost_next = miss_cost_reg;
        if (cfg_write)
        begin
            case (paddr[2])
                dmc_pkg::REG_HIT_COST:  hit_cost_next  = pwdata[dmc_pkg::COST_W-1:0];
                dmc_pkg::REG_MISS_COST: miss_cost_next = pwdata[dmc_pkg::COST_W-1:0];
                default:                hit_cost_next  = hit_cost_reg;
            endcase
        end
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        valid_next     = valid_reg;
        cnt_next       = cnt_reg;
        fwr_valid_next = (state_reg == dmc_pkg::ST_FILL);
        misses_next    = misses_reg;
        reads_next     = reads_reg;
        time_next      = time_reg;
        out_valid_next = out_valid_reg && !response.ready;

        case (state_reg)
            dmc_pkg::ST_IDLE:
            begin
                if (in_accept && (request.command == dmc_pkg::CMD_READ))
                begin
                    state_next = dmc_pkg::ST_LOOKUP;
                end
            end
            dmc_pkg::ST_LOOKUP:
            begin
                cnt_next = '0;
                if (lookup_hit)
                begin
                    state_next = dmc_pkg::ST_DONE;
                end
                else
                begin
                    valid_next[cur_line] = 1'b1;
                    state_next           = dmc_pkg::ST_FILL;
                end
            end
            dmc_pkg::ST_FILL:
            begin
                cnt_next = cnt_reg + WORD_BITS'(1);
                if (cnt_reg == LAST_WORD)
                begin
                    state_next = dmc_pkg::ST_DRAIN;
                end
            end
            dmc_pkg::ST_DRAIN:
            begin
                state_next = dmc_pkg::ST_DONE;
            end
            dmc_pkg::ST_DONE:
            begin
                if (slot_free)
                begin
                    misses_next    = misses_sum[dmc_pkg::CNT_W]
                                   ? dmc_pkg::CNT_MAX : misses_sum[dmc_pkg::CNT_W-1:0];
                    reads_next     = reads_sum[dmc_pkg::CNT_W]
                                   ? dmc_pkg::CNT_MAX : reads_sum[dmc_pkg::CNT_W-1:0];
                    time_next      = time_sum[dmc_pkg::CNT_W]
                                   ? dmc_pkg::CNT_MAX : time_sum[dmc_pkg::CNT_W-1:0];
                    out_valid_next = 1'b1;
                    state_next     = dmc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dmc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dmc_pkg::ST_IDLE;
            valid_reg     <= '0;
            cnt_reg       <= '0;
            fwr_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            hit_cost_reg  <= dmc_pkg::HIT_COST_RESET;
            miss_cost_reg <= dmc_pkg::MISS_COST_RESET;
            misses_reg    <= '0;
            reads_reg     <= '0;
            time_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            cnt_reg       <= cnt_next;
            fwr_valid_reg <= fwr_valid_next;
            out_valid_reg <= out_valid_next;
            hit_cost_reg  <= hit_cost_next;
            miss_cost_reg <= miss_cost_next;
            misses_reg    <= misses_next;
            reads_reg     <= reads_next;
            time_reg      <= time_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fwr_idx_reg <= cnt_reg;
        if (in_accept)
        begin
            addr_reg <= request.address;
        end
        if (state_reg == dmc_pkg::ST_LOOKUP)
        begin
            hit_reg  <= lookup_hit;
            byte_reg <= line_rdata_reg;
        end
        else if (fwr_valid_reg && (fwr_idx_reg == cur_word))
        begin
            byte_reg <= bk_rdata_reg;
        end
        if (out_load)
        begin
            out_hit_reg  <= hit_reg;
            out_byte_reg <= byte_reg;
            out_addr_reg <= addr_reg;
        end
    end

    assign response.valid        = out_valid_reg;
    assign response.hit          = out_hit_reg;
    assign response.read_byte    = out_byte_reg;
    assign response.tag          = dmc_pkg::TAG_W'(out_addr_reg >> (WORD_BITS + LINE_BITS));
    assign response.line_index   = dmc_pkg::LINE_W'(out_line);
    assign response.word_offset  = dmc_pkg::WORD_W'(out_word);
    assign response.block_number = dmc_pkg::BLOCK_W'(out_addr_reg >> WORD_BITS);
    assign response.miss_count   = misses_reg;
    assign response.access_count = reads_reg;
    assign response.elapsed_time = time_reg;

endmodule
